// ----- hdl/bsc_pkg.sv -----
// Shared constants for the barometric sensor compensation pipeline:
// field widths, calibration register indexes and fixed-point constants.
// No dependencies.
package bsc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 23;

    // Calibration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SENS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE = 3'd5;

    // Intermediate widths
    localparam int DT_W   = 26;  // dT, signed
    localparam int CP_W   = 43;  // dT times a coefficient, signed
    localparam int OS_W   = 36;  // OFF and SENS, signed
    localparam int LO_W   = 18;  // low slice of SENS for the split multiply
    localparam int PPL_W  = 42;  // raw pressure times low slice, unsigned
    localparam int PPH_W  = 43;  // raw pressure times high slice, signed
    localparam int SUM_W  = 61;  // full raw pressure times SENS, signed
    localparam int DIFF_W = 41;  // scaled product minus OFF, signed

    // Fixed-point shifts and the temperature base of 20.00 degrees
    localparam int REF_SHIFT   = 8;
    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 6;
    localparam int SENS_SHIFT  = 7;
    localparam int OFF_SCALE   = 17;
    localparam int SENS_SCALE  = 16;
    localparam int PROD_SHIFT  = 21;
    localparam int PRES_SHIFT  = 15;
    localparam logic signed [CP_W-1:0] TEMP_BASE = 43'sd2000;

    // Pipeline depth
    localparam int NUM_STAGES = 6;

endpackage

// ----- hdl/baro_sensor_compensation.sv -----
// Top level of the barometric sensor compensation pipeline.
// Holds the six calibration registers and a six-stage datapath.
// Depends on bsc_pkg.
//
// Usage:
//   Input channel: i_in_valid with i_raw_pressure and i_raw_temperature;
//   the block drives o_in_stall. A transaction is taken on a rising edge
//   with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid with o_temperature_centi (hundredths of a
//   degree) and o_pressure_pa (pascals); the receiver drives i_out_stall.
//   Calibration words are written through i_cfg_wr_en, i_cfg_index and
//   i_cfg_wdata while no transaction is in flight; indexes above five
//   are ignored.
//   Throughput: one transaction per cycle while i_out_stall is low. A
//   result passes in order through the six register stages (dT,
//   coefficient multiplies, OFF/SENS/TEMP, split pressure multiply,
//   partial product sum, final subtract and shift into the output register).
//   Reset (synchronous, active low) clears all stage valid bits and the
//   calibration words to zero.
//   Stall: each stage holds while the one after it is full and held, so
//   bubbles close up; o_in_stall rises only when all six stages are full
//   and the output is stalled. Nothing is dropped or repeated.
module baro_sensor_compensation (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bsc_pkg::COEFF_W-1:0]           i_cfg_wdata,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [bsc_pkg::RAW_W-1:0]             i_raw_pressure,
    input  logic [bsc_pkg::RAW_W-1:0]             i_raw_temperature,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [bsc_pkg::TEMP_W-1:0]     o_temperature_centi,
    output logic signed [bsc_pkg::PRES_W-1:0]     o_pressure_pa
);

    localparam int NS = bsc_pkg::NUM_STAGES;

    // Calibration registers
    logic [bsc_pkg::COEFF_W-1:0] r_sens_coeff;
    logic [bsc_pkg::COEFF_W-1:0] r_offset_coeff;
    logic [bsc_pkg::COEFF_W-1:0] r_sens_temp_coeff;
    logic [bsc_pkg::COEFF_W-1:0] r_offset_temp_coeff;
    logic [bsc_pkg::COEFF_W-1:0] r_ref_temp_coeff;
    logic [bsc_pkg::COEFF_W-1:0] r_temp_slope_coeff;

    // Stage control
    logic [NS:1] r_vld;
    logic [NS:1] stage_rdy;

    // Stage 1
    logic signed [bsc_pkg::DT_W-1:0]   r_dt,   n_dt;
    logic [bsc_pkg::RAW_W-1:0]         r_d1_s1;
    // Stage 2
    logic signed [bsc_pkg::CP_W-1:0]   r_prod_t, n_prod_t;
    logic signed [bsc_pkg::CP_W-1:0]   r_prod_o, n_prod_o;
    logic signed [bsc_pkg::CP_W-1:0]   r_prod_s, n_prod_s;
    logic [bsc_pkg::RAW_W-1:0]         r_d1_s2;
    // Stage 3
    logic signed [bsc_pkg::TEMP_W-1:0] r_temp_s3, n_temp;
    logic signed [bsc_pkg::OS_W-1:0]   r_off_s3, n_off;
    logic signed [bsc_pkg::OS_W-1:0]   r_sens, n_sens;
    logic [bsc_pkg::RAW_W-1:0]         r_d1_s3;
    // Stage 4
    logic [bsc_pkg::PPL_W-1:0]         r_pp_lo, n_pp_lo;
    logic signed [bsc_pkg::PPH_W-1:0]  r_pp_hi, n_pp_hi;
    logic signed [bsc_pkg::TEMP_W-1:0] r_temp_s4;
    logic signed [bsc_pkg::OS_W-1:0]   r_off_s4;
    // Stage 5
    logic signed [bsc_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic signed [bsc_pkg::TEMP_W-1:0] r_temp_s5;
    logic signed [bsc_pkg::OS_W-1:0]   r_off_s5;
    // Stage 6 (output register)
    logic signed [bsc_pkg::TEMP_W-1:0] r_temp_out;
    logic signed [bsc_pkg::PRES_W-1:0] r_pres_out, n_pres;

    // Intermediate terms
    logic signed [bsc_pkg::CP_W-1:0]   temp_full;
    logic signed [bsc_pkg::CP_W-1:0]   off_term;
    logic signed [bsc_pkg::CP_W-1:0]   sens_term;
    logic signed [bsc_pkg::SUM_W-1:0]  prod_scaled;
    logic signed [bsc_pkg::DIFF_W-1:0] pres_diff;
    logic signed [bsc_pkg::DIFF_W-1:0] pres_shifted;

    // Write calibration registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_coeff        <= '0;
            r_offset_coeff      <= '0;
            r_sens_temp_coeff   <= '0;
            r_offset_temp_coeff <= '0;
            r_ref_temp_coeff    <= '0;
            r_temp_slope_coeff  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bsc_pkg::REG_SENS:       r_sens_coeff        <= i_cfg_wdata;
                bsc_pkg::REG_OFFSET:     r_offset_coeff      <= i_cfg_wdata;
                bsc_pkg::REG_SENS_TEMP:  r_sens_temp_coeff   <= i_cfg_wdata;
                bsc_pkg::REG_OFF_TEMP:   r_offset_temp_coeff <= i_cfg_wdata;
                bsc_pkg::REG_REF_TEMP:   r_ref_temp_coeff    <= i_cfg_wdata;
                bsc_pkg::REG_TEMP_SLOPE: r_temp_slope_coeff  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or the next stage moves on
    always_comb begin
        stage_rdy[NS] = !r_vld[NS] || !i_out_stall;
        for (int k = NS - 1; k >= 1; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    end

    assign o_in_stall = !stage_rdy[1];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_rdy[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: dT = D2 - C5 * 2^8
    assign n_dt = $signed({2'b00, i_raw_temperature})
                - $signed({2'b00, r_ref_temp_coeff, bsc_pkg::REF_SHIFT'(0)});

    // Stage 2: dT times C6, C4 and C3
    always_comb begin
        n_prod_t = r_dt * $signed({1'b0, r_temp_slope_coeff});
        n_prod_o = r_dt * $signed({1'b0, r_offset_temp_coeff});
        n_prod_s = r_dt * $signed({1'b0, r_sens_temp_coeff});
    end

    // Stage 3: TEMP, OFF and SENS
    always_comb begin
        temp_full = (r_prod_t >>> bsc_pkg::TEMP_SHIFT) + bsc_pkg::TEMP_BASE;
        off_term  = r_prod_o >>> bsc_pkg::OFF_SHIFT;
        sens_term = r_prod_s >>> bsc_pkg::SENS_SHIFT;
        n_temp    = temp_full[bsc_pkg::TEMP_W-1:0];
        n_off     = $signed({3'b000, r_offset_coeff, bsc_pkg::OFF_SCALE'(0)})
                  + off_term[bsc_pkg::OS_W-1:0];
        n_sens    = $signed({4'b0000, r_sens_coeff, bsc_pkg::SENS_SCALE'(0)})
                  + sens_term[bsc_pkg::OS_W-1:0];
    end

    // Stage 4: split D1 * SENS into two 24 x 18 partial products
    always_comb begin
        n_pp_lo = r_d1_s3 * r_sens[bsc_pkg::LO_W-1:0];
        n_pp_hi = $signed({1'b0, r_d1_s3}) * $signed(r_sens[bsc_pkg::OS_W-1:bsc_pkg::LO_W]);
    end

    // Stage 5: combine partial products
    assign n_sum = (bsc_pkg::SUM_W'(r_pp_hi) <<< bsc_pkg::LO_W)
                 + $signed({{(bsc_pkg::SUM_W-bsc_pkg::PPL_W){1'b0}}, r_pp_lo});

    // Stage 6: P = ((D1 * SENS) >> 21 - OFF) >> 15
    always_comb begin
        prod_scaled  = r_sum >>> bsc_pkg::PROD_SHIFT;
        pres_diff    = $signed(prod_scaled[bsc_pkg::DIFF_W-1:0])
                     - bsc_pkg::DIFF_W'(r_off_s5);
        pres_shifted = pres_diff >>> bsc_pkg::PRES_SHIFT;
        n_pres       = pres_shifted[bsc_pkg::PRES_W-1:0];
    end

    // Payload registers; load with their stage
    always_ff @(posedge i_clk) begin
        if (stage_rdy[1]) begin
            r_dt    <= n_dt;
            r_d1_s1 <= i_raw_pressure;
        end
        if (stage_rdy[2]) begin
            r_prod_t <= n_prod_t;
            r_prod_o <= n_prod_o;
            r_prod_s <= n_prod_s;
            r_d1_s2  <= r_d1_s1;
        end
        if (stage_rdy[3]) begin
            r_temp_s3 <= n_temp;
            r_off_s3  <= n_off;
            r_sens    <= n_sens;
            r_d1_s3   <= r_d1_s2;
        end
        if (stage_rdy[4]) begin
            r_pp_lo   <= n_pp_lo;
            r_pp_hi   <= n_pp_hi;
            r_temp_s4 <= r_temp_s3;
            r_off_s4  <= r_off_s3;
        end
        if (stage_rdy[5]) begin
            r_sum     <= n_sum;
            r_temp_s5 <= r_temp_s4;
            r_off_s5  <= r_off_s4;
        end
        if (stage_rdy[6]) begin
            r_temp_out <= r_temp_s5;
            r_pres_out <= n_pres;
        end
    end

    assign o_out_valid         = r_vld[NS];
    assign o_temperature_centi = r_temp_out;
    assign o_pressure_pa       = r_pres_out;

    // Back-pressure reaches the input only with every stage full
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // A held output keeps the stage behind it occupied
    a_hold_s5 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && i_out_stall && r_vld[NS-1]) |=> r_vld[NS-1])
        else $error("stage five lost its transaction under stall");

    // Reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && (r_vld == '0)))
        else $error("pipeline not empty after reset");

endmodule

// ----- tb/tb_baro_sensor_compensation.sv -----
// Self-checking testbench for the barometric sensor compensation pipeline.
// Predicts temperature and pressure per transaction and checks them in order.
// Depends on bsc_pkg and baro_sensor_compensation.
module tb_baro_sensor_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CFG_INDEXES = 1 << bsc_pkg::CFG_IDX_W;
    localparam int PHASE_ITEMS     = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int LONG_HOLD       = 150;
    localparam int HOLD_PERIOD     = 700;
    localparam int HOLD_OFFSET     = 350;
    localparam int DRAIN_LIMIT     = 50000;
    localparam logic [bsc_pkg::RAW_W-1:0]   RAW_MAX   = '1;
    localparam logic [bsc_pkg::COEFF_W-1:0] COEFF_MAX = '1;

    typedef struct packed {
        logic [bsc_pkg::RAW_W-1:0] raw_pressure;
        logic [bsc_pkg::RAW_W-1:0] raw_temperature;
    } t_raw_sample;

    typedef struct packed {
        logic signed [bsc_pkg::TEMP_W-1:0] temperature_centi;
        logic signed [bsc_pkg::PRES_W-1:0] pressure_pa;
    } t_compensated;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [bsc_pkg::COEFF_W-1:0]       i_cfg_wdata = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [bsc_pkg::RAW_W-1:0]         i_raw_pressure = '0;
    logic [bsc_pkg::RAW_W-1:0]         i_raw_temperature = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [bsc_pkg::TEMP_W-1:0] o_temperature_centi;
    logic signed [bsc_pkg::PRES_W-1:0] o_pressure_pa;

    // Calibration words as the block should hold them
    logic [bsc_pkg::COEFF_W-1:0] cal_sens = '0;
    logic [bsc_pkg::COEFF_W-1:0] cal_offset = '0;
    logic [bsc_pkg::COEFF_W-1:0] cal_sens_temp = '0;
    logic [bsc_pkg::COEFF_W-1:0] cal_off_temp = '0;
    logic [bsc_pkg::COEFF_W-1:0] cal_ref_temp = '0;
    logic [bsc_pkg::COEFF_W-1:0] cal_temp_slope = '0;

    t_raw_sample  pending_samples[$];
    t_compensated expected_readings[$];

    int idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int readings_checked = 0;
    int mismatch_count = 0;

    baro_sensor_compensation u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa)
    );

    always #4 i_clk = ~i_clk;

    // First-order compensation in exact 64-bit signed arithmetic
    function automatic t_compensated predict_compensation(logic [bsc_pkg::RAW_W-1:0] d1,
                                                          logic [bsc_pkg::RAW_W-1:0] d2);
        t_compensated r;
        longint dt, temp, off, sens, pres;
        dt   = longint'(d2) - (longint'(cal_ref_temp) << bsc_pkg::REF_SHIFT);
        temp = longint'(bsc_pkg::TEMP_BASE)
             + ((dt * longint'(cal_temp_slope)) >>> bsc_pkg::TEMP_SHIFT);
        off  = (longint'(cal_offset) << bsc_pkg::OFF_SCALE)
             + ((longint'(cal_off_temp) * dt) >>> bsc_pkg::OFF_SHIFT);
        sens = (longint'(cal_sens) << bsc_pkg::SENS_SCALE)
             + ((longint'(cal_sens_temp) * dt) >>> bsc_pkg::SENS_SHIFT);
        pres = (((longint'(d1) * sens) >>> bsc_pkg::PROD_SHIFT) - off)
             >>> bsc_pkg::PRES_SHIFT;
        r.temperature_centi = temp[bsc_pkg::TEMP_W-1:0];
        r.pressure_pa       = pres[bsc_pkg::PRES_W-1:0];
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [bsc_pkg::COEFF_W-1:0] random_coeff();
        case ($urandom_range(9))
            0: return '0;
            1: return COEFF_MAX;
            default: return bsc_pkg::COEFF_W'($urandom);
        endcase
    endfunction

    // Full-range readings, field extremes, and temperatures close to the
    // reference so that dT lands near zero on either side
    function automatic t_raw_sample random_sample();
        t_raw_sample s;
        int t;
        s.raw_pressure    = bsc_pkg::RAW_W'($urandom);
        s.raw_temperature = bsc_pkg::RAW_W'($urandom);
        case ($urandom_range(19)) inside
            0: s.raw_pressure = '0;
            1: s.raw_pressure = RAW_MAX;
            2: s.raw_temperature = '0;
            3: s.raw_temperature = RAW_MAX;
            [4:6]: begin
                t = int'({cal_ref_temp, 8'h00}) + int'($urandom_range(511)) - 256;
                if (t < 0)
                    t = 0;
                if (t > int'(RAW_MAX))
                    t = int'(RAW_MAX);
                s.raw_temperature = t[bsc_pkg::RAW_W-1:0];
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_raw_sample make_sample(logic [bsc_pkg::RAW_W-1:0] d1,
                                                logic [bsc_pkg::RAW_W-1:0] d2);
        t_raw_sample s;
        s.raw_pressure    = d1;
        s.raw_temperature = d2;
        return s;
    endfunction

    task automatic write_coeff(logic [bsc_pkg::CFG_IDX_W-1:0] idx,
                               logic [bsc_pkg::COEFF_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            bsc_pkg::REG_SENS:       cal_sens = value;
            bsc_pkg::REG_OFFSET:     cal_offset = value;
            bsc_pkg::REG_SENS_TEMP:  cal_sens_temp = value;
            bsc_pkg::REG_OFF_TEMP:   cal_off_temp = value;
            bsc_pkg::REG_REF_TEMP:   cal_ref_temp = value;
            bsc_pkg::REG_TEMP_SLOPE: cal_temp_slope = value;
            default: ;  // unused indexes must leave every word alone
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Write all six words, then junk to the unused indexes
    task automatic load_calibration(logic [bsc_pkg::COEFF_W-1:0] c1,
                                    logic [bsc_pkg::COEFF_W-1:0] c2,
                                    logic [bsc_pkg::COEFF_W-1:0] c3,
                                    logic [bsc_pkg::COEFF_W-1:0] c4,
                                    logic [bsc_pkg::COEFF_W-1:0] c5,
                                    logic [bsc_pkg::COEFF_W-1:0] c6);
        write_coeff(bsc_pkg::REG_SENS, c1);
        write_coeff(bsc_pkg::REG_OFFSET, c2);
        write_coeff(bsc_pkg::REG_SENS_TEMP, c3);
        write_coeff(bsc_pkg::REG_OFF_TEMP, c4);
        write_coeff(bsc_pkg::REG_REF_TEMP, c5);
        write_coeff(bsc_pkg::REG_TEMP_SLOPE, c6);
        for (int idx = bsc_pkg::REG_TEMP_SLOPE + 1; idx < NUM_CFG_INDEXES; idx++)
            write_coeff(bsc_pkg::CFG_IDX_W'(idx), random_coeff());
    endtask

    // Hold until every queued transaction has gone through and come back
    task automatic drain_pipeline();
        int waited;
        waited = 0;
        while ((pending_samples.size() != 0 || i_in_valid || expected_readings.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (bsc_pkg::NUM_STAGES + 2) @(posedge i_clk);
    endtask

    // Input driver: hold a stalled transaction, otherwise idle or send the next one
    always @(posedge i_clk) begin : input_driver
        t_raw_sample s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_readings.push_back(
                    predict_compensation(i_raw_pressure, i_raw_temperature));
                send_gap = gap_length();
            end
            if (i_in_valid && o_in_stall) begin
                // keep offering the same transaction
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s = pending_samples.pop_front();
                i_raw_pressure    <= s.raw_pressure;
                i_raw_temperature <= s.raw_temperature;
                i_in_valid        <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each accepted result, then pick the next stall
    always @(posedge i_clk) begin : output_monitor
        t_compensated exp_r;
        logic         stall_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                readings_checked++;
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected reading %0d: temperature %0d pressure %0d",
                                 readings_checked, o_temperature_centi, o_pressure_pa);
                end else begin
                    exp_r = expected_readings.pop_front();
                    if (exp_r.temperature_centi !== o_temperature_centi ||
                        exp_r.pressure_pa !== o_pressure_pa) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("reading %0d: temperature exp %0d got %0d, %s%0d got %0d",
                                     readings_checked, exp_r.temperature_centi,
                                     o_temperature_centi, "pressure exp ",
                                     exp_r.pressure_pa, o_pressure_pa);
                    end
                end
                // long hold-off so the pipeline fills and stalls its input
                if (readings_checked % HOLD_PERIOD == HOLD_OFFSET)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else begin
                stall_left = gap_length();
                stall_next = (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
            i_out_stall <= stall_next;
        end
    end

    // Stimulus: directed corners first, then randomised calibration phases
    initial begin : stimulus
        int phase_pct[5];
        phase_pct = '{0, 20, 50, 0, 75};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration: every word zero
        idle_pct = 30;
        pending_samples.push_back(make_sample('0, '0));
        pending_samples.push_back(make_sample(RAW_MAX, RAW_MAX));
        pending_samples.push_back(make_sample('0, RAW_MAX));
        pending_samples.push_back(make_sample(RAW_MAX, '0));
        drain_pipeline();

        // every word at full scale, dT at zero and just below
        load_calibration(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
        pending_samples.push_back(make_sample('0, '0));
        pending_samples.push_back(make_sample(RAW_MAX, RAW_MAX));
        pending_samples.push_back(make_sample('0, RAW_MAX));
        pending_samples.push_back(make_sample(RAW_MAX, '0));
        pending_samples.push_back(make_sample(RAW_MAX, {COEFF_MAX, 8'h00}));
        pending_samples.push_back(make_sample(RAW_MAX, {COEFF_MAX, 8'h00} - 1'b1));
        drain_pipeline();

        // typical factory calibration and readings
        load_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
        pending_samples.push_back(make_sample(24'd6465444, 24'd8077636));
        pending_samples.push_back(make_sample(24'd6465444, {16'd31553, 8'h00}));
        pending_samples.push_back(make_sample(RAW_MAX, '0));
        pending_samples.push_back(make_sample('0, RAW_MAX));
        drain_pipeline();

        // random calibration per phase, a mix of idling levels
        foreach (phase_pct[ph]) begin
            load_calibration(random_coeff(), random_coeff(), random_coeff(),
                             random_coeff(), random_coeff(), random_coeff());
            idle_pct = phase_pct[ph];
            repeat (PHASE_ITEMS) pending_samples.push_back(random_sample());
            drain_pipeline();
        end

        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bsc_pkg.sv
hdl/baro_sensor_compensation.sv
tb/tb_baro_sensor_compensation.sv
